// ===== rtl/core/aspc_pkg.sv =====
// ----------------------------------------------------------------------------
// aspc_pkg
// Shared widths, defaults and request codes of the angular sector classifier.
// ----------------------------------------------------------------------------
package aspc_pkg;

  localparam int MAX_CAMERAS_DEF = 64;
  localparam int COORD_BITS_DEF  = 32;

  localparam int ENTRY_BITS = 6;
  localparam int RCS_BITS   = 32;
  localparam int SECT_BITS  = 6;
  localparam int CNT_BITS   = 7;
  localparam int SUM_BITS   = 38;

  localparam logic [CNT_BITS-1:0] COUNT_RESET = 7'd1;

  localparam logic REQ_WRITE    = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

endpackage

// ===== rtl/core/aspc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// aspc_cfg_if
// Write channel for the camera count register.
// ----------------------------------------------------------------------------
interface aspc_cfg_if
  import aspc_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CNT_BITS-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/aspc_req_if.sv =====
// ----------------------------------------------------------------------------
// aspc_req_if
// Request channel: camera table writes and point classify requests.
// ----------------------------------------------------------------------------
interface aspc_req_if
  import aspc_pkg::*;
  #(parameter int COORD_BITS = COORD_BITS_DEF)
  ();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [ENTRY_BITS-1:0]        entry_index;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_z;
  logic signed [RCS_BITS-1:0]   rcs_value;

  modport source (output valid, output req_type, output entry_index, output pos_x,
                  output pos_z, output rcs_value, input ready);
  modport sink   (input valid, input req_type, input entry_index, input pos_x,
                  input pos_z, input rcs_value, output ready);
endinterface

// ===== rtl/core/aspc_res_if.sv =====
// ----------------------------------------------------------------------------
// aspc_res_if
// Result channel: one classification result per classify request.
// ----------------------------------------------------------------------------
interface aspc_res_if
  import aspc_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic                       matched;
  logic [SECT_BITS-1:0]       sector_index;
  logic [CNT_BITS-1:0]        match_count;
  logic signed [SUM_BITS-1:0] score_sum;

  modport source (output valid, output matched, output sector_index,
                  output match_count, output score_sum, input ready);
  modport sink   (input valid, input matched, input sector_index,
                  input match_count, input score_sum, output ready);
endinterface

// ===== rtl/core/angular_sector_point_classifier_top.sv =====
// ----------------------------------------------------------------------------
// angular_sector_point_classifier_top
// Camera table in one synchronous memory; a sector pipeline walks the table.
// ----------------------------------------------------------------------------
// A write transaction stores a camera (x, z, cross section) and returns
// nothing. A classify transaction walks the table one camera entry per
// cycle through a single memory read port: it reads entry count-1, then 0 up to
// count-1, then 0 again, so a three-entry window always holds previous, current
// and next camera. Each sector then runs through sums, differences, six
// parallel cross products and a sign compare before it is accumulated. The
// count is saturated to MAX_CAMERAS; a count of zero skips the walk. The block
// works on one request at a time; a finished result waits in the output
// register while the next request is taken. The table needs no clear after
// reset: reading an entry never written gives undefined fields.
// ----------------------------------------------------------------------------
module angular_sector_point_classifier_top
  import aspc_pkg::*;
  #(
    parameter int MAX_CAMERAS = MAX_CAMERAS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
  )
  (
    input  logic       clk,
    input  logic       rst,
    aspc_cfg_if.sink   cfg,
    aspc_req_if.sink   req,
    aspc_res_if.source res
  );

  // index, count and walk step widths
  localparam int IW = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int NW = $clog2(MAX_CAMERAS + 1);
  localparam int SW = $clog2(MAX_CAMERAS + 2);
  // arithmetic widths: doubled coordinates, differences, products
  localparam int CW = COORD_BITS;
  localparam int AW = CW + 1;
  localparam int DW = CW + 2;
  localparam int PW = 2 * DW;
  localparam int EW = 2 * CW + RCS_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FINISH} state_t;

  state_t state;

  logic [CNT_BITS-1:0] camera_count;
  logic [NW-1:0]       num;
  logic [NW-1:0]       num_next;
  logic [SW-1:0]       step;
  logic [SW-1:0]       step_last;
  logic                rd_busy;
  logic [IW-1:0]       rd_addr;

  logic signed [CW-1:0] pt_x;
  logic signed [CW-1:0] pt_z;

  // result register
  logic                       res_valid;
  logic                       res_matched;
  logic [SECT_BITS-1:0]       res_sector_index;
  logic [CNT_BITS-1:0]        res_match_count;
  logic signed [SUM_BITS-1:0] res_score_sum;

  // accumulators
  logic [SECT_BITS-1:0]       acc_last;
  logic [CNT_BITS-1:0]        acc_hits;
  logic signed [SUM_BITS-1:0] acc_sum;

  logic req_accept;
  logic wr_accept;
  logic cls_accept;
  logic sector_done;

  assign req.ready  = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign req_accept = req.valid && req.ready;
  assign wr_accept  = req_accept && (req.req_type == REQ_WRITE);
  assign cls_accept = req_accept && (req.req_type == REQ_CLASSIFY);

  assign res.valid        = res_valid;
  assign res.matched      = res_matched;
  assign res.sector_index = res_sector_index;
  assign res.match_count  = res_match_count;
  assign res.score_sum    = res_score_sum;

  // saturate the count to the table size
  always_comb begin
    if (32'(camera_count) > MAX_CAMERAS) begin
      num_next = NW'(MAX_CAMERAS);
    end else begin
      num_next = NW'(camera_count);
    end
  end

  // Walk order: count-1, 0 .. count-1, 0.
  assign step_last = SW'(num) + SW'(1);

  always_comb begin
    if (step == '0) begin
      rd_addr = IW'(num - NW'(1));
    end else if (step == step_last) begin
      rd_addr = '0;
    end else begin
      rd_addr = IW'(step - SW'(1));
    end
  end

  // --------------------------------------------------------------------------
  // Camera table: one entry is {rcs, z, x}. Write on a write transaction,
  // read one entry per cycle during the walk.
  // --------------------------------------------------------------------------
  logic [EW-1:0]        mem [MAX_CAMERAS];
  logic [EW-1:0]        rd_data;
  logic                 rd_vld;
  logic [SW-1:0]        rd_tag;
  logic [IW+5:0]        wr_wide;

  assign wr_wide = (IW + 6)'(req.entry_index);

  always_ff @(posedge clk) begin
    if (wr_accept && (32'(req.entry_index) < MAX_CAMERAS)) begin
      mem[wr_wide[IW-1:0]] <= {req.rcs_value, req.pos_z, req.pos_x};
    end
    if (rd_busy) begin
      rd_data <= mem[rd_addr];
    end
    rd_tag <= step;
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_busy;
    end
  end

  // --------------------------------------------------------------------------
  // Sector pipeline
  //   s1: window of previous / current / next camera
  //   s2: doubled midpoints and doubled point
  //   s3: edge differences
  //   s4: cross products
  //   s5: edge signs
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]       w_x [3];
  logic signed [CW-1:0]       w_z [3];
  logic signed [RCS_BITS-1:0] w_r [3];
  logic                       s1_vld;
  logic [IW-1:0]              s1_idx;

  logic signed [AW-1:0]       s2_ax, s2_az, s2_bx, s2_bz, s2_px, s2_pz;
  logic signed [RCS_BITS-1:0] s2_rcs;
  logic                       s2_vld;
  logic [IW-1:0]              s2_idx;

  logic signed [DW-1:0]       s3_pxbx, s3_azbz, s3_axbx, s3_pzbz, s3_nbz;
  logic signed [DW-1:0]       s3_nbx, s3_pxax, s3_naz, s3_nax, s3_pzaz;
  logic signed [DW-1:0]       s3_px, s3_pz;
  logic signed [RCS_BITS-1:0] s3_rcs;
  logic                       s3_vld;
  logic [IW-1:0]              s3_idx;

  logic signed [PW-1:0]       s4_p1l, s4_p1r, s4_p2l, s4_p2r, s4_p3l, s4_p3r;
  logic signed [RCS_BITS-1:0] s4_rcs;
  logic                       s4_vld;
  logic [IW-1:0]              s4_idx;

  logic                       s5_n1, s5_n2, s5_n3;
  logic signed [RCS_BITS-1:0] s5_rcs;
  logic                       s5_vld;
  logic [IW-1:0]              s5_idx;
  logic [IW+SECT_BITS-1:0]    s5_idx_wide;

  always_ff @(posedge clk) begin
    // advance the window on each returned entry
    if (rd_vld) begin
      w_x[0] <= w_x[1];
      w_x[1] <= w_x[2];
      w_x[2] <= rd_data[CW-1:0];
      w_z[0] <= w_z[1];
      w_z[1] <= w_z[2];
      w_z[2] <= rd_data[2*CW-1:CW];
      w_r[0] <= w_r[1];
      w_r[1] <= w_r[2];
      w_r[2] <= rd_data[EW-1:2*CW];
    end
    s1_idx <= IW'(rd_tag - SW'(2));

    s2_ax  <= AW'(w_x[0]) + AW'(w_x[1]);
    s2_az  <= AW'(w_z[0]) + AW'(w_z[1]);
    s2_bx  <= AW'(w_x[1]) + AW'(w_x[2]);
    s2_bz  <= AW'(w_z[1]) + AW'(w_z[2]);
    s2_px  <= {pt_x, 1'b0};
    s2_pz  <= {pt_z, 1'b0};
    s2_rcs <= w_r[1];
    s2_idx <= s1_idx;

    s3_pxbx <= DW'(s2_px) - DW'(s2_bx);
    s3_azbz <= DW'(s2_az) - DW'(s2_bz);
    s3_axbx <= DW'(s2_ax) - DW'(s2_bx);
    s3_pzbz <= DW'(s2_pz) - DW'(s2_bz);
    s3_nbz  <= -DW'(s2_bz);
    s3_nbx  <= -DW'(s2_bx);
    s3_pxax <= DW'(s2_px) - DW'(s2_ax);
    s3_naz  <= -DW'(s2_az);
    s3_nax  <= -DW'(s2_ax);
    s3_pzaz <= DW'(s2_pz) - DW'(s2_az);
    s3_px   <= DW'(s2_px);
    s3_pz   <= DW'(s2_pz);
    s3_rcs  <= s2_rcs;
    s3_idx  <= s2_idx;

    // edge through b and the origin: p.x * b.z < b.x * p.z, both sides negated
    s4_p1l <= PW'(s3_pxbx) * PW'(s3_azbz);
    s4_p1r <= PW'(s3_axbx) * PW'(s3_pzbz);
    s4_p2l <= PW'(s3_nbx) * PW'(s3_pz);
    s4_p2r <= PW'(s3_px) * PW'(s3_nbz);
    s4_p3l <= PW'(s3_pxax) * PW'(s3_naz);
    s4_p3r <= PW'(s3_nax) * PW'(s3_pzaz);
    s4_rcs <= s3_rcs;
    s4_idx <= s3_idx;

    s5_n1  <= (s4_p1l < s4_p1r);
    s5_n2  <= (s4_p2l < s4_p2r);
    s5_n3  <= (s4_p3l < s4_p3r);
    s5_rcs <= s4_rcs;
    s5_idx <= s4_idx;

    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else begin
      // the first two entries of a walk only prime the window
      s1_vld <= rd_vld && (rd_tag >= SW'(2));
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  assign s5_idx_wide = (IW + SECT_BITS)'(s5_idx);
  assign sector_done = s5_vld && (s5_idx == IW'(num - NW'(1)));

  // --------------------------------------------------------------------------
  // Control: request intake, walk counter, accumulation, result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      camera_count <= COUNT_RESET;
      rd_busy      <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        camera_count <= cfg.data;
      end

      // drop the result once taken
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end

      // accumulate a sector that holds the point
      if (s5_vld && (s5_n1 == s5_n2) && (s5_n2 == s5_n3)) begin
        acc_last <= s5_idx_wide[SECT_BITS-1:0];
        acc_hits <= acc_hits + CNT_BITS'(1);
        acc_sum  <= acc_sum + SUM_BITS'(s5_rcs);
      end

      // advance the read walk
      if (rd_busy) begin
        step <= step + SW'(1);
        if (step == step_last) begin
          rd_busy <= 1'b0;
        end
      end

      case (state)
        ST_IDLE: begin
          if (cls_accept) begin
            pt_x     <= req.pos_x;
            pt_z     <= req.pos_z;
            num      <= num_next;
            step     <= '0;
            acc_last <= '0;
            acc_hits <= '0;
            acc_sum  <= '0;
            if (num_next == '0) begin
              state <= ST_FINISH;
            end else begin
              rd_busy <= 1'b1;
              state   <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (sector_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold until the result register is free
          if (!res_valid || res.ready) begin
            res_valid        <= 1'b1;
            res_matched      <= (acc_hits != '0);
            res_sector_index <= acc_last;
            res_match_count  <= acc_hits;
            res_score_sum    <= acc_sum;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/aspc_checker.sv =====
// ----------------------------------------------------------------------------
// aspc_checker
// Port-level checks on the result channel of the sector classifier.
// ----------------------------------------------------------------------------
module aspc_checker
  import aspc_pkg::*;
  (
    input logic                       clk,
    input logic                       rst,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic                       res_matched,
    input logic [SECT_BITS-1:0]       res_sector_index,
    input logic [CNT_BITS-1:0]        res_match_count,
    input logic signed [SUM_BITS-1:0] res_score_sum
  );

  // hold a stalled result
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_match_count) && $stable(res_score_sum)
      && $stable(res_sector_index) && $stable(res_matched))
    else $error("result payload changed while stalled");

  // the match flag agrees with the match count
  a_matched_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_matched == (res_match_count != '0)))
    else $error("matched flag disagrees with match count");

  // no match leaves index and sum at zero
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_matched |-> (res_sector_index == '0) && (res_score_sum == '0))
    else $error("unmatched result carries index or sum");

endmodule

bind angular_sector_point_classifier_top aspc_checker u_aspc_checker (
  .clk              (clk),
  .rst              (rst),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_matched      (res.matched),
  .res_sector_index (res.sector_index),
  .res_match_count  (res.match_count),
  .res_score_sum    (res.score_sum)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the angular sector point classifier. It loads camera
// tables (ordered rings and scattered ones), sweeps the camera count across
// its range and classifies points against a local sector predictor. Every
// result is compared field by field, in order, with the predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import aspc_pkg::*;

  localparam int  MAX_CAM       = MAX_CAMERAS_DEF;
  // Settle wait: long enough for a full table walk through the pipeline.
  localparam int  SETTLE_CYCLES = MAX_CAM + 16;
  localparam int  LONG_HOLD     = 400;
  localparam int  RANDOM_PHASES = 6;
  localparam int  PHASE_PROBES  = 24;
  localparam real TWO_PI        = 6.283185307179586;

  typedef enum int {RCS_RANDOM, RCS_HIGH, RCS_LOW} rcs_fill_t;

  typedef struct packed {
    logic                 matched;
    logic [SECT_BITS-1:0] sector_index;
    logic [CNT_BITS-1:0]  match_count;
    logic [SUM_BITS-1:0]  score_sum;
  } sector_result_t;

  logic clk;
  logic rst;

  aspc_cfg_if cfg_ch ();
  aspc_req_if req_ch ();
  aspc_res_if res_ch ();

  angular_sector_point_classifier_top DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .res (res_ch)
  );

  // Local copy of the block state, updated in acceptance order.
  logic signed [31:0]   cam_x   [MAX_CAM];
  logic signed [31:0]   cam_z   [MAX_CAM];
  logic signed [31:0]   cam_rcs [MAX_CAM];
  int                   eff_count;

  sector_result_t expected_sectors [$];
  int             mismatch_count;
  int             result_number;

  // Shared controls between the sender and the receiver processes.
  bit idle_on;
  bit long_hold_req;
  bit req_held;
  bit res_held;
  int ring_bits;
  bit ring_scattered;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("angular_sector_point_classifier_top: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string text);
    $display("%0t: %s", $time, text);
    mismatch_count++;
  endtask

  // Sign of the edge cross product: true when (p - c) x (a - c) is negative.
  function automatic logic sector_edge_negative(input logic signed [71:0] px, pz,
                                                input logic signed [71:0] ax, az,
                                                input logic signed [71:0] cx, cz);
    logic signed [71:0] lhs;
    logic signed [71:0] rhs;
    lhs = (px - cx) * (az - cz);
    rhs = (ax - cx) * (pz - cz);
    return lhs < rhs;
  endfunction

  // Predict one classification: walk every sector in use with doubled
  // midpoints and a doubled point, so every product stays exact.
  function automatic sector_result_t classify_point(input logic signed [31:0] x, z);
    logic signed [71:0]         px, pz, ax, az, bx, bz, org;
    logic signed [SUM_BITS-1:0] acc;
    logic [CNT_BITS-1:0]        hits;
    logic [SECT_BITS-1:0]       last;
    logic                       n1, n2, n3;
    int                         prv, nxt;
    sector_result_t             r;
    acc  = '0;
    hits = '0;
    last = '0;
    org  = '0;
    px   = x;
    px   = px + px;
    pz   = z;
    pz   = pz + pz;
    for (int i = 0; i < eff_count; i++) begin
      prv = (i == 0) ? eff_count - 1 : i - 1;
      nxt = (i + 1 == eff_count) ? 0 : i + 1;
      ax  = cam_x[prv];
      ax  = ax + cam_x[i];
      az  = cam_z[prv];
      az  = az + cam_z[i];
      bx  = cam_x[i];
      bx  = bx + cam_x[nxt];
      bz  = cam_z[i];
      bz  = bz + cam_z[nxt];
      n1  = sector_edge_negative(px, pz, ax, az, bx, bz);
      n2  = sector_edge_negative(px, pz, bx, bz, org, org);
      n3  = sector_edge_negative(px, pz, org, org, ax, az);
      if (n1 == n2 && n2 == n3) begin
        last = i[SECT_BITS-1:0];
        hits = hits + 1'b1;
        acc  = acc + cam_rcs[i];
      end
    end
    r.matched      = (hits != '0);
    r.sector_index = last;
    r.match_count  = hits;
    r.score_sum    = acc;
    return r;
  endfunction

  // Send one request. Valid stays high across back-to-back transactions and is
  // dropped only when a gap follows, so it never toggles twice in one step.
  task automatic send_item(input logic kind, input logic [ENTRY_BITS-1:0] idx,
                           input logic signed [31:0] x, z, rcs);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      if (req_held) req_ch.valid <= 1'b0;
      req_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.entry_index <= idx;
    req_ch.pos_x       <= x;
    req_ch.pos_z       <= z;
    req_ch.rcs_value   <= rcs;
    req_held = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    if (kind == REQ_WRITE) begin
      cam_x[idx]   = x;
      cam_z[idx]   = z;
      cam_rcs[idx] = rcs;
    end else begin
      expected_sectors.push_back(classify_point(x, z));
    end
  endtask

  task automatic classify_at(input logic signed [31:0] x, z);
    send_item(REQ_CLASSIFY, ENTRY_BITS'($urandom), x, z, $urandom);
  endtask

  // Drop valid and hold until every predicted result has been taken.
  task automatic wait_results_drained();
    if (req_held) req_ch.valid <= 1'b0;
    req_held = 1'b0;
    do @(posedge clk); while (expected_sectors.size() != 0);
  endtask

  // A write item leaves no result behind, so also let the pipeline run dry.
  task automatic settle_block();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_camera_count(input logic [CNT_BITS-1:0] value);
    settle_block();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    eff_count = (value > MAX_CAM) ? MAX_CAM : int'(value);
  endtask

  // Load entries 0..n-1 with cameras in angular order around the origin
  // (counterclockwise or clockwise), or scattered anywhere when asked.
  task automatic load_ring(input int n, input bit ccw, input int rbits,
                           input bit scattered, input rcs_fill_t fill);
    real                ang, rad;
    logic signed [31:0] x, z, rcs;
    ring_bits      = rbits;
    ring_scattered = scattered;
    for (int i = 0; i < n; i++) begin
      ang = TWO_PI * (i + ($urandom_range(0, 1023) / 1024.0 - 0.5) * 0.8) / n;
      if (!ccw) ang = -ang;
      rad = (2.0 ** (rbits - 1)) * (1.0 + 0.99 * $urandom_range(0, 1023) / 1024.0);
      x   = $rtoi(rad * $cos(ang));
      z   = $rtoi(rad * $sin(ang));
      if (scattered) begin
        x = $urandom;
        z = $urandom;
      end
      case (fill)
        RCS_HIGH: rcs = 32'sh7FFF_FFFF;
        RCS_LOW:  rcs = 32'sh8000_0000;
        default:  rcs = $urandom;
      endcase
      send_item(REQ_WRITE, i[ENTRY_BITS-1:0], x, z, rcs);
    end
  endtask

  // One point against the current table: mostly inside or near the ring,
  // some on sector boundaries or on the single-camera line, the rest noise.
  task automatic send_probe();
    int                 pick, j, k;
    real                ang, rad;
    logic signed [31:0] x, z;
    pick = $urandom_range(0, 9);
    x    = $urandom;
    z    = $urandom;
    if (!ring_scattered && eff_count > 0) begin
      if (eff_count == 1 && pick < 4) begin
        k = $urandom_range(0, 4) - 2;
        x = cam_x[0] * k;
        z = cam_z[0] * k;
      end else if (pick == 9) begin
        j = $urandom_range(0, eff_count - 1);
        k = (j + 1 == eff_count) ? 0 : j + 1;
        x = (cam_x[j] + cam_x[k]) >>> 1;
        z = (cam_z[j] + cam_z[k]) >>> 1;
      end else if (pick < 8) begin
        ang = TWO_PI * $urandom_range(0, 65535) / 65536.0;
        rad = (2.0 ** ring_bits) * 1.2 * $urandom_range(0, 1023) / 1024.0;
        x   = $rtoi(rad * $cos(ang));
        z   = $rtoi(rad * $sin(ang));
      end
    end
    classify_at(x, z);
  endtask

  // Reset count of one: a single camera sector degenerates to the line
  // through the origin and the camera.
  task automatic test_single_camera();
    send_item(REQ_WRITE, '0, 32'sd196608, -32'sd131072, 32'sh0001_8000);
    classify_at(32'sd196608, -32'sd131072);
    classify_at(32'sd393216, -32'sd262144);
    classify_at(-32'sd196608, 32'sd131072);
    classify_at('0, '0);
    classify_at(32'sd196608, 32'sd131072);
  endtask

  // A full counterclockwise ring holds the origin in every sector; with all
  // cross sections at the top and then the bottom value the sum reaches its upper and then its lower end.
  task automatic test_full_ring();
    write_camera_count(CNT_BITS'(MAX_CAM));
    load_ring(MAX_CAM, 1'b1, 20, 1'b0, RCS_HIGH);
    classify_at('0, '0);
    load_ring(MAX_CAM, 1'b1, 20, 1'b0, RCS_LOW);
    classify_at('0, '0);
  endtask

  // Count of zero, counts above the table size, and extreme coordinates.
  task automatic test_count_extremes();
    write_camera_count('0);
    classify_at('0, '0);
    classify_at($urandom, $urandom);
    write_camera_count(7'd127);
    classify_at('0, '0);
    write_camera_count(7'd65);
    classify_at(32'sh8000_0000, 32'sh7FFF_FFFF);
    write_camera_count(CNT_BITS'(MAX_CAM));
    classify_at(32'sh7FFF_FFFF, 32'sh8000_0000);
    classify_at(32'sh8000_0000, 32'sh8000_0000);
    classify_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(REQ_WRITE, '0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(REQ_WRITE, '1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    classify_at('0, '0);
    classify_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    classify_at(32'sh8000_0000, 32'sh8000_0000);
  endtask

  // Random phases: a new count, a fresh table, then points mixed with
  // stray table writes that may break the ring.
  task automatic test_random_phases();
    int                 pick;
    logic [CNT_BITS-1:0] count;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0:       count = '0;
        1:       count = 7'd1;
        2:       count = CNT_BITS'(MAX_CAM);
        3:       count = CNT_BITS'($urandom_range(MAX_CAM + 1, 127));
        default: count = CNT_BITS'($urandom_range(2, 12));
      endcase
      write_camera_count(count);
      if (eff_count > 0)
        load_ring(eff_count, 1'($urandom_range(0, 1)), $urandom_range(8, 30),
                  ($urandom_range(0, 4) == 0), RCS_RANDOM);
      for (int i = 0; i < PHASE_PROBES; i++) begin
        if ($urandom_range(0, 6) == 0)
          send_item(REQ_WRITE, ENTRY_BITS'($urandom), $urandom, $urandom, $urandom);
        else
          send_probe();
      end
    end
  endtask

  // Hold off results for a long stretch while requests keep coming with no
  // gaps, then pause the sender until everything has drained and probe again with gaps.
  task automatic test_backpressure();
    write_camera_count(7'd4);
    load_ring(4, 1'b1, 24, 1'b0, RCS_RANDOM);
    long_hold_req = 1'b1;
    idle_on       = 1'b0;
    for (int i = 0; i < 12; i++) send_probe();
    idle_on = 1'b1;
    wait_results_drained();
    for (int i = 0; i < 8; i++) send_probe();
  endtask

  // Result side: stall at random, take one result per transaction and check
  // it against the oldest prediction.
  initial begin
    int             stall;
    sector_result_t got, want;
    res_ch.ready <= 1'b0;
    res_held      = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (long_hold_req) begin
        stall         = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall != 0) begin
        if (res_held) res_ch.ready <= 1'b0;
        res_held = 1'b0;
        repeat (stall) @(posedge clk);
      end
      if (!res_held) res_ch.ready <= 1'b1;
      res_held = 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.matched      = res_ch.matched;
      got.sector_index = res_ch.sector_index;
      got.match_count  = res_ch.match_count;
      got.score_sum    = res_ch.score_sum;
      result_number++;
      if (expected_sectors.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  result_number));
      end else begin
        want = expected_sectors.pop_front();
        if (got.matched !== want.matched)
          report_mismatch($sformatf("result %0d: matched %b, expected %b",
                                    result_number, got.matched, want.matched));
        if (got.sector_index !== want.sector_index)
          report_mismatch($sformatf("result %0d: sector_index %0d, expected %0d",
                                    result_number, got.sector_index,
                                    want.sector_index));
        if (got.match_count !== want.match_count)
          report_mismatch($sformatf("result %0d: match_count %0d, expected %0d",
                                    result_number, got.match_count,
                                    want.match_count));
        if (got.score_sum !== want.score_sum)
          report_mismatch($sformatf("result %0d: score_sum %0d, expected %0d",
                                    result_number, $signed(got.score_sum),
                                    $signed(want.score_sum)));
      end
    end
  end

  // Main sequence: reset once, run each test in turn, drain, then decide.
  initial begin
    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_WRITE;
    req_ch.entry_index <= '0;
    req_ch.pos_x       <= '0;
    req_ch.pos_z       <= '0;
    req_ch.rcs_value   <= '0;
    mismatch_count = 0;
    result_number  = 0;
    idle_on        = 1'b1;
    long_hold_req  = 1'b0;
    req_held       = 1'b0;
    ring_bits      = 20;
    ring_scattered = 1'b0;
    eff_count      = int'(COUNT_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_camera();
    test_full_ring();
    test_count_extremes();
    test_random_phases();
    test_backpressure();

    settle_block();
    if (mismatch_count == 0) begin
      $display("angular_sector_point_classifier_top: match");
    end else begin
      $display("angular_sector_point_classifier_top: mismatch");
    end
    $finish;
  end

endmodule
